[rtl/bbp_pkg.sv]
// bimodal branch predictor: shared constants, types and helper functions
// no dependencies; used by the top level, controller, datapath and testbench through scoped names
`default_nettype none

package bbp_pkg;

    localparam int MAX_INDEX_BITS = 12;
    localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
    localparam int CTR_W          = 2;
    localparam int CFG_W          = 4;
    localparam int ADDR_W         = 32;
    localparam int TOTAL_W        = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 72;
    localparam int OUT_USED_W     = 2 + 2 * TOTAL_W;

    localparam logic [CTR_W-1:0] CTR_RESET        = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX          = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN          = 2'd0;
    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

    typedef logic [MAX_INDEX_BITS-1:0] t_idx;

    typedef struct packed {
        logic clr_we;
        t_idx clr_addr;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_sts;

    function automatic t_idx index_mask(input logic [CFG_W-1:0] bits);
        t_idx mask;
        if (32'(bits) >= MAX_INDEX_BITS) begin
            mask = '1;
        end else begin
            mask = t_idx'((32'd1 << bits) - 32'd1);
        end
        return mask;
    endfunction

    function automatic logic [CTR_W-1:0] ctr_next(input logic [CTR_W-1:0] ctr,
                                                  input logic taken);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (taken) begin
            if (ctr != CTR_MAX) begin
                res = ctr + 2'd1;
            end
        end else begin
            if (ctr != CTR_MIN) begin
                res = ctr - 2'd1;
            end
        end
        return res;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

[rtl/bimodal_branch_predictor.sv]
// bimodal branch predictor, 2-bit saturating counters, top level
// one branch at a time: the next is taken in only after the last is written back
// (table read, then counter write-back through the single ram write port)
// reset: synchronous, active low; then a clearing pass sets every counter
// to weakly taken, during which no branch is taken in
// depends on bbp_pkg, bbp_ctrl, bbp_dp
`default_nettype none

module bimodal_branch_predictor (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // branch_address[31:0], taken[32], zero fill
    input  wire logic [bbp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // predicted_taken[0], mispredicted[1], predictions_so_far[33:2],
    // mispredictions_so_far[65:34], zero fill
    output logic      [bbp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bbp_pkg::CFG_W-1:0]          i_cfg_data
);

    bbp_pkg::t_cmd cmd;
    bbp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    bbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bbp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

[rtl/bbp_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/bbp_ctrl.sv]
// controller: table clearing pass after reset and per-branch sequencing
// depends on bbp_pkg
`default_nettype none

module bbp_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire bbp_pkg::t_sts i_sts,
    output bbp_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]    r_state, n_state;
    bbp_pkg::t_idx r_clr_addr, n_clr_addr;
    logic          accept;
    logic          commit;

    assign accept = (r_state == ST_IDLE) && i_in_valid;
    assign commit = (r_state == ST_LOOKUP) && !i_sts.out_stall;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cmd.clr_we   = (r_state == ST_CLEAR);
    assign o_cmd.clr_addr = r_clr_addr;
    assign o_cmd.accept   = accept;
    assign o_cmd.commit   = commit;

endmodule

`default_nettype wire

[rtl/bbp_dp.sv]
// datapath: counter table, index config, running totals, output register
// depends on bbp_pkg and bbp_ram
`default_nettype none

module bbp_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [bbp_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic [bbp_pkg::IN_TDATA_W-1:0]     i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [bbp_pkg::OUT_TDATA_W-1:0]    o_out_data,
    input  wire bbp_pkg::t_cmd                      i_cmd,
    output bbp_pkg::t_sts                           o_sts
);

    logic [bbp_pkg::CFG_W-1:0]   r_index_bits;
    bbp_pkg::t_idx               r_idx;
    logic                        r_taken;
    bbp_pkg::t_idx               rd_idx;
    logic [bbp_pkg::CTR_W-1:0]   rd_ctr;
    logic [bbp_pkg::CTR_W-1:0]   upd_ctr;
    logic                        pred;
    logic                        wrong;
    logic                        ram_we;
    bbp_pkg::t_idx               ram_waddr;
    logic [bbp_pkg::CTR_W-1:0]   ram_wdata;
    logic [bbp_pkg::TOTAL_W-1:0] r_pred_total, n_pred_total;
    logic [bbp_pkg::TOTAL_W-1:0] r_mis_total, n_mis_total;
    logic                        r_out_valid;
    logic [bbp_pkg::OUT_USED_W-1:0] r_out_data;

    // table index from address bit 2 upward
    assign rd_idx = i_in_data[bbp_pkg::MAX_INDEX_BITS+1:2]
                  & bbp_pkg::index_mask(r_index_bits);

    assign pred    = rd_ctr[1];
    assign wrong   = pred ^ r_taken;
    assign upd_ctr = bbp_pkg::ctr_next(rd_ctr, r_taken);

    assign ram_we    = i_cmd.clr_we || i_cmd.commit;
    assign ram_waddr = i_cmd.clr_we ? i_cmd.clr_addr : r_idx;
    assign ram_wdata = i_cmd.clr_we ? bbp_pkg::CTR_RESET : upd_ctr;

    bbp_ram #(
        .WIDTH (bbp_pkg::CTR_W),
        .DEPTH (bbp_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_idx),
        .o_rdata (rd_ctr)
    );

    assign n_pred_total = bbp_pkg::sat_inc(r_pred_total);
    assign n_mis_total  = wrong ? bbp_pkg::sat_inc(r_mis_total) : r_mis_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= bbp_pkg::INDEX_BITS_RESET;
            r_pred_total <= '0;
            r_mis_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_index_bits <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_pred_total <= n_pred_total;
                r_mis_total  <= n_mis_total;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx   <= rd_idx;
            r_taken <= i_in_data[bbp_pkg::ADDR_W];
        end
        if (i_cmd.commit) begin
            r_out_data <= {n_mis_total, n_pred_total, wrong, pred};
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = {{(bbp_pkg::OUT_TDATA_W - bbp_pkg::OUT_USED_W){1'b0}},
                              r_out_data};

endmodule

`default_nettype wire

[verif/bimodal_branch_predictor_tb.sv]
// testbench for the bimodal branch predictor: stream stimulus, own counter-table
// predictor in a small scoreboard class, field-by-field result checks
// depends on bbp_pkg and bimodal_branch_predictor
`default_nettype none

module bimodal_branch_predictor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bbp_pkg::TOTAL_W-1:0] misses;
        logic [bbp_pkg::TOTAL_W-1:0] branches;
        logic                        mispredicted;
        logic                        predicted_taken;
    } t_verdict;

    class branch_scoreboard;
        logic [bbp_pkg::CTR_W-1:0]   counters [bbp_pkg::TABLE_DEPTH];
        logic [bbp_pkg::CFG_W-1:0]   index_bits;
        logic [bbp_pkg::TOTAL_W-1:0] branch_total;
        logic [bbp_pkg::TOTAL_W-1:0] miss_total;
        t_verdict                    verdicts [$];
        int                          errors;

        function new();
            foreach (counters[i]) counters[i] = 2'd2;
            index_bits   = 4'd12;
            branch_total = '0;
            miss_total   = '0;
            errors       = 0;
        endfunction

        function void set_index_bits(logic [bbp_pkg::CFG_W-1:0] bits);
            index_bits = bits;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $realtime, msg);
        endtask

        function void note_branch(logic [31:0] addr, logic taken);
            int unsigned   width;
            bbp_pkg::t_idx slot;
            logic [1:0]    ctr;
            t_verdict      v;
            width = (index_bits > bbp_pkg::MAX_INDEX_BITS) ? bbp_pkg::MAX_INDEX_BITS
                                                           : index_bits;
            slot  = bbp_pkg::t_idx'((addr >> 2) & ((32'd1 << width) - 32'd1));
            ctr   = counters[slot];
            v.predicted_taken = ctr[1];
            v.mispredicted    = (ctr[1] != taken);
            if (taken && ctr != 2'd3) begin
                ctr = ctr + 2'd1;
            end else if (!taken && ctr != 2'd0) begin
                ctr = ctr - 2'd1;
            end
            counters[slot] = ctr;
            if (branch_total != '1) branch_total = branch_total + 1;
            if (v.mispredicted && miss_total != '1) miss_total = miss_total + 1;
            v.branches = branch_total;
            v.misses   = miss_total;
            verdicts.push_back(v);
        endfunction

        task check_result(logic [bbp_pkg::OUT_TDATA_W-1:0] data);
            t_verdict v;
            if (verdicts.size() == 0) begin
                report($sformatf("unexpected result beat, data %h", data));
                return;
            end
            v = verdicts.pop_front();
            if (data[0] !== v.predicted_taken)
                report($sformatf("predicted_taken got %b expected %b",
                                 data[0], v.predicted_taken));
            if (data[1] !== v.mispredicted)
                report($sformatf("mispredicted got %b expected %b",
                                 data[1], v.mispredicted));
            if (data[33:2] !== v.branches)
                report($sformatf("predictions_so_far got %0d expected %0d",
                                 data[33:2], v.branches));
            if (data[65:34] !== v.misses)
                report($sformatf("mispredictions_so_far got %0d expected %0d",
                                 data[65:34], v.misses));
        endtask
    endclass

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // branch_address[31:0], taken[32], zero fill
    logic [bbp_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // predicted_taken[0], mispredicted[1], predictions_so_far[33:2],
    // mispredictions_so_far[65:34], zero fill
    logic [bbp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [bbp_pkg::CFG_W-1:0]           i_cfg_data    = '0;

    branch_scoreboard sb;
    bit               idle_on = 1'b1;
    int               widths_seen = 0;

    bimodal_branch_predictor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task send_branch(logic [31:0] addr, logic taken);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, taken, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_branch(addr, taken);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    task write_index_bits(logic [bbp_pkg::CFG_W-1:0] bits);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_index_bits(bits);
        i_cfg_valid <= 1'b0;
        widths_seen++;
    endtask

    // result side: check each beat, stall in random bursts while idle_on is set
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [31:0]               pool [8];
        int                        bias [8];
        logic [bbp_pkg::CFG_W-1:0] widths [8];
        int                        k;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // counter walk on one entry: down to saturation, then up to saturation
        repeat (4) send_branch(32'h0000_0000, 1'b0);
        repeat (4) send_branch(32'h0000_0000, 1'b1);
        // low two bits and bits above the index do not select the entry
        send_branch(32'h0000_0003, 1'b0);
        send_branch(32'h0000_4001, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFC, 1'b0);
        send_branch(32'h0000_3FFC, 1'b0);
        send_branch(32'h8000_0000, 1'b0);

        // zero index width: everything shares entry 0
        write_index_bits(4'd0);
        send_branch(32'h1234_5678, 1'b0);
        send_branch(32'hFFFF_FFFC, 1'b1);
        send_branch(32'h0000_0004, 1'b1);
        // width above the table size behaves as the full width
        write_index_bits(4'd15);
        send_branch(32'h0000_3FFC, 1'b1);
        send_branch(32'hFFFF_FFFC, 1'b1);
        send_branch(32'h0000_4000, 1'b1);
        write_index_bits(4'd1);
        send_branch(32'h0000_0004, 1'b0);
        send_branch(32'h0000_000C, 1'b0);

        widths = '{4'd12, 4'd0, 4'd15, 4'd1, 4'd0, 4'd0, 4'd0, 4'd12};
        for (int p = 4; p < 7; p++) widths[p] = 4'($urandom_range(0, 15));

        for (int p = 0; p < 8; p++) begin
            if (p == 7) idle_on = 1'b0;
            write_index_bits(widths[p]);
            // a few hot branches with strong or mixed bias, some aliased high bits
            for (int j = 0; j < 8; j++) begin
                pool[j] = $urandom;
                if (j >= 6) pool[j] = pool[0] ^ (32'($urandom_range(1, 255)) << 14);
                bias[j] = (j % 3 == 0) ? $urandom_range(0, 15)
                        : (j % 3 == 1) ? $urandom_range(85, 100) : $urandom_range(30, 70);
            end
            for (int n = 0; n < 150; n++) begin
                if (p == 3 && n == 75) wait_drained();
                if ($urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, 7);
                    send_branch(pool[k], $urandom_range(0, 99) < bias[k]);
                end else begin
                    send_branch($urandom, 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d branches over %0d index width settings, %0d mispredicted",
                 sb.branch_total, widths_seen + 1, sb.miss_total);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
